>>> rtl/tcp_syn_scan_tracker_macros.svh
// ----------------------------------------------------------------------------
// SYN scan tracker assertion macros
// Concurrent assertion shorthands shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_SYN_SCAN_TRACKER_MACROS_SVH
`define TCP_SYN_SCAN_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define TSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TSST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TSST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/tsst_pkg.sv
// ----------------------------------------------------------------------------
// SYN scan tracker package
// Item types, codes and protocol constants of the SYN scan tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsst_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_NUM_TCP  = 8'd6;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] IP_MIN_LEN     = 16'd34;

  typedef enum logic [1:0] {
    REQ_PACKET  = 2'd0,
    REQ_BLOCK   = 2'd1,
    REQ_UNBLOCK = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_DONE = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BRD,
    ST_BCHK,
    ST_MRD,
    ST_MCHK,
    ST_QRD,
    ST_QWAIT,
    ST_DRD,
    ST_DCHK,
    ST_SRD,
    ST_SWR,
    ST_FIN
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] packet_length;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  header_words;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        ack_flag;
    logic [2:0]  history_index;
  } in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        record_valid;
    logic [31:0] rec_src_ip;
    logic [31:0] rec_dst_ip;
    logic [15:0] rec_src_port;
    logic [15:0] rec_dst_port;
    logic [31:0] syn_total;
    logic        entry_found;
    logic        table_full;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/tcp_syn_scan_tracker.sv
// Early verdicts are on the result ports in the cycle after the item is accepted.
// Control items scan the block table; queries then scan the metric table and may read one history
// slot, and pure SYN packets then scan the metric table, search the history of the source and
// shift it when the port is new. Each table entry is read and then compared; reads are registered.
// One item is in flight; early verdict items can follow every cycle while idle. Results never stall.
// After reset a clearing pass over the metric and block tables holds busy.
// ----------------------------------------------------------------------------
// SYN scan tracker
// Tracks pure SYN packets per source in memory tables and handles block lists.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tcp_syn_scan_tracker_macros.svh"

module tcp_syn_scan_tracker #(
  parameter int METRIC_ENTRIES = 64,
  parameter int HISTORY_DEPTH  = 8,
  parameter int BLOCK_ENTRIES  = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tsst_pkg::in_t item_i,
  output logic               result_valid_o,
  output tsst_pkg::out_t     result_o
);

  localparam int MW   = (METRIC_ENTRIES > 1) ? $clog2(METRIC_ENTRIES) : 1;
  localparam int BW   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int HN   = METRIC_ENTRIES * HISTORY_DEPTH;
  localparam int HAW  = (HN > 1) ? $clog2(HN) : 1;
  localparam int MAXA = (METRIC_ENTRIES > BLOCK_ENTRIES) ? METRIC_ENTRIES : BLOCK_ENTRIES;
  localparam int MAXN = (MAXA > HISTORY_DEPTH) ? MAXA : HISTORY_DEPTH;
  localparam int CW   = $clog2(MAXN + 1);

  typedef struct packed {
    logic          valid;
    logic [31:0]   ip;
    logic [31:0]   cnt;
    logic [FW-1:0] fill;
  } mrow_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
  } brow_t;

  mrow_t       mmem [METRIC_ENTRIES];
  brow_t       bmem [BLOCK_ENTRIES];
  logic [15:0] hmem [HN];

  mrow_t mrd_q;
  brow_t brd_q;
  logic [15:0] hrd_q;

  tsst_pkg::state_e state_q, state_d;
  tsst_pkg::in_t    req_q, req_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             bfree_q, bfree_d;
  logic [BW-1:0]    bfree_idx_q, bfree_idx_d;
  logic             mfree_q, mfree_d;
  logic [MW-1:0]    mfree_idx_q, mfree_idx_d;
  logic [MW-1:0]    midx_q, midx_d;
  mrow_t            mrow_q, mrow_d;
  logic             dup_q, dup_d;
  tsst_pkg::out_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;

  logic          mw_en, bw_en, hw_en;
  logic [MW-1:0] mw_addr;
  logic [BW-1:0] bw_addr;
  logic [HAW-1:0] hw_addr, h_raddr, hbase;
  mrow_t         mw_data;
  brow_t         bw_data;
  logic [15:0]   hw_data;

  logic          accept, early;
  tsst_pkg::verdict_e early_v;
  logic [15:0]   tcp_min;
  logic          b_hit, b_last, b_free_now, m_hit, m_last, m_free_now;
  logic [BW-1:0] b_free_idx;
  logic [MW-1:0] m_free_idx;
  logic          is_syn, slot_ok, d_hit, d_last, s_last, clr_last;
  logic [31:0]   cnt_inc;
  logic [FW-1:0] fill_inc;
  tsst_pkg::out_t rec;

  assign accept  = start && !busy;
  assign tcp_min = tsst_pkg::IP_MIN_LEN + {10'd0, item_i.header_words, 2'b00};

  always_comb begin
    early   = 1'b0;
    early_v = tsst_pkg::VERDICT_PASS;
    if (item_i.req_type == tsst_pkg::REQ_PACKET) begin
      early = 1'b1;
      if (item_i.packet_length < tsst_pkg::ETH_HDR_LEN) begin
        early_v = tsst_pkg::VERDICT_DROP;
      end else if (item_i.eth_type != tsst_pkg::ETHERTYPE_IPV4) begin
        early_v = tsst_pkg::VERDICT_PASS;
      end else if (item_i.packet_length < tsst_pkg::IP_MIN_LEN) begin
        early_v = tsst_pkg::VERDICT_DROP;
      end else if (item_i.ip_protocol != tsst_pkg::PROTO_NUM_TCP) begin
        early_v = tsst_pkg::VERDICT_PASS;
      end else if (item_i.packet_length < tcp_min) begin
        early_v = tsst_pkg::VERDICT_DROP;
      end else begin
        early = 1'b0;
      end
    end
  end

  assign b_hit      = brd_q.valid && (brd_q.ip == req_q.src_ip);
  assign b_last     = idx_q == CW'(BLOCK_ENTRIES - 1);
  assign b_free_now = bfree_q || !brd_q.valid;
  assign b_free_idx = bfree_q ? bfree_idx_q : idx_q[BW-1:0];
  assign m_hit      = mrd_q.valid && (mrd_q.ip == req_q.src_ip);
  assign m_last     = idx_q == CW'(METRIC_ENTRIES - 1);
  assign m_free_now = mfree_q || !mrd_q.valid;
  assign m_free_idx = mfree_q ? mfree_idx_q : idx_q[MW-1:0];
  assign is_syn     = req_q.syn_flag && !req_q.ack_flag;
  assign slot_ok    = (32'(req_q.history_index) < HISTORY_DEPTH) &&
                      (32'(req_q.history_index) < 32'(mrd_q.fill));
  assign d_hit      = hrd_q == req_q.dst_port;
  assign d_last     = CW'(idx_q + CW'(1)) == CW'(mrow_q.fill);
  assign s_last     = idx_q == CW'(1);
  assign clr_last   = idx_q == CW'(MAXN - 1);
  assign cnt_inc    = (mrd_q.cnt == 32'hFFFF_FFFF) ? mrd_q.cnt : mrd_q.cnt + 32'd1;
  assign fill_inc   = (32'(mrow_q.fill) < HISTORY_DEPTH) ? FW'(mrow_q.fill + FW'(1))
                                                          : mrow_q.fill;
  assign hbase      = HAW'(midx_q) * HAW'(HISTORY_DEPTH);

  always_comb begin
    case (state_q)
      tsst_pkg::ST_QRD: h_raddr = hbase + HAW'(req_q.history_index);
      tsst_pkg::ST_SRD: h_raddr = hbase + HAW'(idx_q) - HAW'(1);
      default:          h_raddr = hbase + HAW'(idx_q);
    endcase
  end

  always_comb begin
    rec              = '0;
    rec.verdict      = tsst_pkg::VERDICT_PASS;
    rec.record_valid = 1'b1;
    rec.rec_src_ip   = req_q.src_ip;
    rec.rec_dst_ip   = req_q.dst_ip;
    rec.rec_src_port = req_q.src_port;
    rec.rec_dst_port = req_q.dst_port;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsst_pkg::ST_CLEAR: if (clr_last) state_d = tsst_pkg::ST_IDLE;
      tsst_pkg::ST_IDLE:  if (accept && !early) state_d = tsst_pkg::ST_BRD;
      tsst_pkg::ST_BRD:   state_d = tsst_pkg::ST_BCHK;
      tsst_pkg::ST_BCHK: begin
        if (b_hit || b_last) begin
          if ((req_q.req_type == tsst_pkg::REQ_PACKET && !b_hit && is_syn) ||
              req_q.req_type == tsst_pkg::REQ_QUERY) begin
            state_d = tsst_pkg::ST_MRD;
          end else begin
            state_d = tsst_pkg::ST_IDLE;
          end
        end else begin
          state_d = tsst_pkg::ST_BRD;
        end
      end
      tsst_pkg::ST_MRD:   state_d = tsst_pkg::ST_MCHK;
      tsst_pkg::ST_MCHK: begin
        if (m_hit || m_last) begin
          if (req_q.req_type == tsst_pkg::REQ_QUERY) begin
            state_d = (m_hit && slot_ok) ? tsst_pkg::ST_QRD : tsst_pkg::ST_IDLE;
          end else begin
            state_d = m_hit ? tsst_pkg::ST_DRD : tsst_pkg::ST_IDLE;
          end
        end else begin
          state_d = tsst_pkg::ST_MRD;
        end
      end
      tsst_pkg::ST_QRD:   state_d = tsst_pkg::ST_QWAIT;
      tsst_pkg::ST_QWAIT: state_d = tsst_pkg::ST_IDLE;
      tsst_pkg::ST_DRD:   state_d = tsst_pkg::ST_DCHK;
      tsst_pkg::ST_DCHK: begin
        if (d_hit) begin
          state_d = tsst_pkg::ST_FIN;
        end else if (d_last) begin
          state_d = (HISTORY_DEPTH > 1) ? tsst_pkg::ST_SRD : tsst_pkg::ST_FIN;
        end else begin
          state_d = tsst_pkg::ST_DRD;
        end
      end
      tsst_pkg::ST_SRD:   state_d = tsst_pkg::ST_SWR;
      tsst_pkg::ST_SWR:   state_d = s_last ? tsst_pkg::ST_FIN : tsst_pkg::ST_SRD;
      tsst_pkg::ST_FIN:   state_d = tsst_pkg::ST_IDLE;
      default:            state_d = tsst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    bfree_d     = bfree_q;
    bfree_idx_d = bfree_idx_q;
    mfree_d     = mfree_q;
    mfree_idx_d = mfree_idx_q;
    midx_d      = midx_q;
    mrow_d      = mrow_q;
    dup_d       = dup_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    mw_en       = 1'b0;
    mw_addr     = idx_q[MW-1:0];
    mw_data     = '0;
    bw_en       = 1'b0;
    bw_addr     = idx_q[BW-1:0];
    bw_data     = '0;
    hw_en       = 1'b0;
    hw_addr     = hbase + HAW'(idx_q);
    hw_data     = hrd_q;
    case (state_q)
      tsst_pkg::ST_CLEAR: begin
        mw_en = 32'(idx_q) < METRIC_ENTRIES;
        bw_en = 32'(idx_q) < BLOCK_ENTRIES;
        idx_d = clr_last ? '0 : CW'(idx_q + CW'(1));
      end
      tsst_pkg::ST_IDLE: begin
        if (accept) begin
          req_d   = item_i;
          idx_d   = '0;
          bfree_d = 1'b0;
          mfree_d = 1'b0;
          dup_d   = 1'b0;
          if (early) begin
            res_d         = '0;
            res_d.verdict = early_v;
            res_vld_d     = 1'b1;
          end
        end
      end
      tsst_pkg::ST_BCHK: begin
        if (!brd_q.valid && !bfree_q) begin
          bfree_d     = 1'b1;
          bfree_idx_d = idx_q[BW-1:0];
        end
        idx_d = CW'(idx_q + CW'(1));
        if (b_hit || b_last) begin
          idx_d = '0;
          res_d = '0;
          res_vld_d = 1'b1;
          case (req_q.req_type)
            tsst_pkg::REQ_BLOCK: begin
              res_d.verdict = tsst_pkg::VERDICT_DONE;
              if (b_hit) begin
                res_d.entry_found = 1'b1;
              end else if (b_free_now) begin
                bw_en             = 1'b1;
                bw_addr           = b_free_idx;
                bw_data           = '{valid: 1'b1, ip: req_q.src_ip};
                res_d.entry_found = 1'b1;
              end else begin
                res_d.table_full = 1'b1;
              end
            end
            tsst_pkg::REQ_UNBLOCK: begin
              res_d.verdict = tsst_pkg::VERDICT_DONE;
              if (b_hit) begin
                bw_en             = 1'b1;
                res_d.entry_found = 1'b1;
              end
            end
            tsst_pkg::REQ_QUERY: begin
              res_vld_d = 1'b0;
            end
            default: begin
              if (b_hit) begin
                res_d.verdict = tsst_pkg::VERDICT_DROP;
              end else if (is_syn) begin
                res_vld_d = 1'b0;
              end else begin
                res_d.verdict = tsst_pkg::VERDICT_PASS;
              end
            end
          endcase
        end
      end
      tsst_pkg::ST_MCHK: begin
        if (!mrd_q.valid && !mfree_q) begin
          mfree_d     = 1'b1;
          mfree_idx_d = idx_q[MW-1:0];
        end
        idx_d = CW'(idx_q + CW'(1));
        if (m_hit || m_last) begin
          idx_d  = '0;
          midx_d = idx_q[MW-1:0];
          mrow_d = mrd_q;
          if (req_q.req_type == tsst_pkg::REQ_QUERY) begin
            res_d         = '0;
            res_d.verdict = tsst_pkg::VERDICT_DONE;
            if (m_hit) begin
              res_d.entry_found = 1'b1;
              res_d.syn_total   = mrd_q.cnt;
            end
            res_vld_d = !(m_hit && slot_ok);
          end else if (m_hit) begin
            mrow_d.cnt = cnt_inc;
          end else begin
            res_d     = rec;
            res_vld_d = 1'b1;
            if (m_free_now) begin
              mw_en           = 1'b1;
              mw_addr         = m_free_idx;
              mw_data         = '{valid: 1'b1, ip: req_q.src_ip, cnt: 32'd1, fill: FW'(1)};
              hw_en           = 1'b1;
              hw_addr         = HAW'(m_free_idx) * HAW'(HISTORY_DEPTH);
              hw_data         = req_q.dst_port;
              res_d.syn_total = 32'd1;
            end else begin
              res_d.table_full = 1'b1;
            end
          end
        end
      end
      tsst_pkg::ST_QWAIT: begin
        res_d              = '0;
        res_d.verdict      = tsst_pkg::VERDICT_DONE;
        res_d.entry_found  = 1'b1;
        res_d.syn_total    = mrow_q.cnt;
        res_d.rec_dst_port = hrd_q;
        res_vld_d          = 1'b1;
      end
      tsst_pkg::ST_DCHK: begin
        idx_d = CW'(idx_q + CW'(1));
        if (d_hit) begin
          dup_d = 1'b1;
        end else if (d_last) begin
          idx_d = CW'(HISTORY_DEPTH - 1);
        end
      end
      tsst_pkg::ST_SWR: begin
        hw_en = 1'b1;
        idx_d = CW'(idx_q - CW'(1));
      end
      tsst_pkg::ST_FIN: begin
        mw_en   = 1'b1;
        mw_addr = midx_q;
        mw_data = '{valid: 1'b1, ip: req_q.src_ip, cnt: mrow_q.cnt,
                    fill: dup_q ? mrow_q.fill : fill_inc};
        hw_en   = !dup_q;
        hw_addr = hbase;
        hw_data = req_q.dst_port;
        res_d             = rec;
        res_d.entry_found = 1'b1;
        res_d.syn_total   = mrow_q.cnt;
        res_vld_d         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      mmem[mw_addr] <= mw_data;
    end
    mrd_q <= mmem[idx_q[MW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (bw_en) begin
      bmem[bw_addr] <= bw_data;
    end
    brd_q <= bmem[idx_q[BW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      hmem[hw_addr] <= hw_data;
    end
    hrd_q <= hmem[h_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsst_pkg::ST_CLEAR;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
      bfree_q   <= 1'b0;
      mfree_q   <= 1'b0;
      dup_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
      bfree_q   <= bfree_d;
      mfree_q   <= mfree_d;
      dup_q     <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    bfree_idx_q <= bfree_idx_d;
    mfree_idx_q <= mfree_idx_d;
    midx_q      <= midx_d;
    mrow_q      <= mrow_d;
    res_q       <= res_d;
  end

  assign busy           = state_q != tsst_pkg::ST_IDLE;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  `TSST_ASSERT_NEXT(a_scan_starts, clk_i, rst_ni, accept && !early, busy, "Scan item did not raise busy.")
  `TSST_ASSERT_IMP(a_record_pass, clk_i, rst_ni, result_valid_o && result_o.record_valid, result_o.verdict == tsst_pkg::VERDICT_PASS, "Record with non-pass verdict.")
  `TSST_ASSERT_IMP(a_full_not_found, clk_i, rst_ni, result_valid_o && result_o.table_full, !result_o.entry_found, "Full table with entry found.")

endmodule

`default_nettype wire
